### rtl/e2e_window_state_machine_assert.svh
// ----------------------------------------------------------------------------
// e2e_window_state_machine_assert.svh
// Assertion macros used by the E2E window state machine sequencer (e2e_seq).
// ----------------------------------------------------------------------------
`ifndef E2E_WINDOW_STATE_MACHINE_ASSERT_SVH
`define E2E_WINDOW_STATE_MACHINE_ASSERT_SVH

// checked out of reset only
`define E2E_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define E2E_CHECK_ALL(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/e2e_pkg.sv
// ----------------------------------------------------------------------------
// e2e_pkg
// Types and constants of the E2E window state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package e2e_pkg;

	typedef enum logic [1:0] {
		ST_NODATA  = 2'd0,
		ST_INIT    = 2'd1,
		ST_INVALID = 2'd2,
		ST_VALID   = 2'd3
	} e2e_state_t;

	typedef enum logic [2:0] {
		PS_OK          = 3'd0,
		PS_REPEATED    = 3'd1,
		PS_WRONG_SEQ   = 3'd2,
		PS_ERROR       = 3'd3,
		PS_NOT_AVAIL   = 3'd4,
		PS_NO_NEW_DATA = 3'd5
	} prof_status_t;

	typedef enum logic [1:0] {
		W_OK       = 2'd0,
		W_ERROR    = 2'd1,
		W_NOTAVAIL = 2'd2,
		W_OTHER    = 2'd3
	} win_code_t;

	typedef enum logic [2:0] {
		REG_WIN_INIT    = 3'd0,
		REG_WIN_INVALID = 3'd1,
		REG_WIN_VALID   = 3'd2,
		REG_MAX_ERR_INI = 3'd3,
		REG_MIN_OK_INI  = 3'd4,
		REG_MAX_ERR_INV = 3'd5,
		REG_MIN_OK_INV  = 3'd6,
		REG_CLR_INV     = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SQ_BOOT,
		SQ_IDLE,
		SQ_WRITE,
		SQ_COUNT,
		SQ_DECIDE,
		SQ_FILL,
		SQ_CLEAR,
		SQ_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_FILL,
		ACT_CLEAR
	} win_act_t;

	typedef struct packed {
		logic [4:0] win_init;
		logic [4:0] win_invalid;
		logic [4:0] win_valid;
		logic [4:0] max_err_init;
		logic [4:0] min_ok_init;
		logic [4:0] max_err_inv;
		logic [4:0] min_ok_inv;
		logic       clr_inv;
	} e2e_cfg_t;

	localparam e2e_cfg_t CFG_RESET = '{
		win_init:     5'd4,
		win_invalid:  5'd4,
		win_valid:    5'd8,
		max_err_init: 5'd0,
		min_ok_init:  5'd2,
		max_err_inv:  5'd0,
		min_ok_inv:   5'd2,
		clr_inv:      1'b0
	};

	function automatic win_code_t status_to_code(input logic [2:0] st);
		win_code_t c;
		unique case (st)
			PS_OK:        c = W_OK;
			PS_ERROR:     c = W_ERROR;
			PS_NOT_AVAIL: c = W_NOTAVAIL;
			default:      c = W_OTHER;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

### rtl/e2e_cfg_regs.sv
// ----------------------------------------------------------------------------
// e2e_cfg_regs
// APB register file holding the window sizes, threshold settings and clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

module e2e_cfg_regs import e2e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output e2e_cfg_t         cfg
);

	e2e_cfg_t cfg_q;
	cfg_idx_t idx;

	assign idx    = cfg_idx_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_WIN_INIT:    cfg_q.win_init     <= pwdata[4:0];
				REG_WIN_INVALID: cfg_q.win_invalid  <= pwdata[4:0];
				REG_WIN_VALID:   cfg_q.win_valid    <= pwdata[4:0];
				REG_MAX_ERR_INI: cfg_q.max_err_init <= pwdata[4:0];
				REG_MIN_OK_INI:  cfg_q.min_ok_init  <= pwdata[4:0];
				REG_MAX_ERR_INV: cfg_q.max_err_inv  <= pwdata[4:0];
				REG_MIN_OK_INV:  cfg_q.min_ok_inv   <= pwdata[4:0];
				REG_CLR_INV:     cfg_q.clr_inv      <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIN_INIT:    prdata = 32'(cfg_q.win_init);
			REG_WIN_INVALID: prdata = 32'(cfg_q.win_invalid);
			REG_WIN_VALID:   prdata = 32'(cfg_q.win_valid);
			REG_MAX_ERR_INI: prdata = 32'(cfg_q.max_err_init);
			REG_MIN_OK_INI:  prdata = 32'(cfg_q.min_ok_init);
			REG_MAX_ERR_INV: prdata = 32'(cfg_q.max_err_inv);
			REG_MIN_OK_INV:  prdata = 32'(cfg_q.min_ok_inv);
			REG_CLR_INV:     prdata = 32'(cfg_q.clr_inv);
		endcase
	end

endmodule

`default_nettype wire

### rtl/e2e_window_ram.sv
// ----------------------------------------------------------------------------
// e2e_window_ram
// Status window store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module e2e_window_ram import e2e_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  win_code_t                    wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output win_code_t                    rdata
);

	win_code_t mem_q [DEPTH];
	win_code_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/e2e_seq.sv
// ----------------------------------------------------------------------------
// e2e_seq
// Sequencer: writes each status into the window, counts the window through
// the read port, applies the state rules and runs fill and clear sweeps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "e2e_window_state_machine_assert.svh"

module e2e_seq import e2e_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  e2e_cfg_t         cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  profile_status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       machine_state,
	output logic [4:0]       ok_total,
	output logic [4:0]       error_total,
	output logic             we,
	output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] waddr,
	output win_code_t        wdata,
	output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] raddr,
	input  win_code_t        rdata
);

	localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW   = $clog2(MAX_WINDOW + 1);
	localparam int TW   = CW + 1;
	localparam int CMPW = ((CW > 5) ? CW : 5) + 1;

	seq_state_t sq_q, sq_d;
	e2e_state_t mstate_q;
	e2e_state_t dec_state;
	win_act_t   dec_act;

	logic [AW-1:0] top_q, top_next, fill_idx_q, clr_idx_q;
	logic [CW-1:0] ok_q, err_q, acc_ok_q, acc_err_q, rd_idx_q, fill_cur_q, fill_n_q;
	logic [CW-1:0] sz_init, sz_inv, sz_valid, sz_cur;
	logic [2:0]    status_q;
	logic          rd_v_s1;
	logic          clr_last, fill_last, count_done, out_free;

	logic          out_valid_q;
	e2e_state_t    out_state_q;
	logic [4:0]    out_ok_q, out_err_q;

	logic [CMPW-1:0] ok_c, err_c, fill_c;
	logic            init_pass, init_fail, inv_pass, inv_err;

	function automatic logic [CW-1:0] clamp_sz(input logic [4:0] s);
		logic [CW-1:0] r;
		if (s == '0) begin
			r = CW'(1);
		end else if (int'(s) > MAX_WINDOW) begin
			r = CW'(MAX_WINDOW);
		end else begin
			r = CW'(s);
		end
		return r;
	endfunction

	assign sz_init  = clamp_sz(cfg.win_init);
	assign sz_inv   = clamp_sz(cfg.win_invalid);
	assign sz_valid = clamp_sz(cfg.win_valid);

	always_comb begin
		unique case (mstate_q)
			ST_NODATA:  sz_cur = sz_inv;
			ST_INIT:    sz_cur = sz_init;
			ST_INVALID: sz_cur = sz_inv;
			ST_VALID:   sz_cur = sz_valid;
		endcase
	end

	// ring top wraps once it reaches or passes the window end
	assign top_next   = ((TW'(top_q) + TW'(1)) >= TW'(sz_cur)) ? '0 : top_q + 1'b1;
	assign clr_last   = (clr_idx_q == AW'(MAX_WINDOW - 1));
	assign fill_last  = (fill_n_q == fill_cur_q - 1'b1);
	assign count_done = (rd_idx_q == sz_cur);
	assign out_free   = !out_valid_q || out_ready;

	// threshold rules, top_q already holds the advanced top
	assign ok_c      = CMPW'(acc_ok_q);
	assign err_c     = CMPW'(acc_err_q);
	assign fill_c    = (top_q == '0) ? CMPW'(sz_init) : CMPW'(top_q);
	assign init_pass = (err_c <= CMPW'(cfg.max_err_init)) && (ok_c >= CMPW'(cfg.min_ok_init));
	assign init_fail = (err_c > CMPW'(cfg.max_err_init)) ||
		((fill_c + CMPW'(cfg.min_ok_init)) > (CMPW'(sz_init) + ok_c));
	assign inv_pass  = (err_c <= CMPW'(cfg.max_err_inv)) && (ok_c >= CMPW'(cfg.min_ok_inv));
	assign inv_err   = (err_c > CMPW'(cfg.max_err_inv));

	always_comb begin
		dec_state = mstate_q;
		dec_act   = ACT_NONE;
		unique case (mstate_q)
			ST_NODATA: begin
				if (top_q == '0) begin
					dec_state = ST_INVALID;
					if (cfg.clr_inv) begin
						dec_act = ACT_CLEAR;
					end
				end else if (status_q != PS_ERROR && status_q != PS_NO_NEW_DATA) begin
					dec_state = ST_INIT;
					dec_act   = ACT_CLEAR;
				end
			end
			ST_INIT: begin
				if (init_pass) begin
					dec_state = ST_VALID;
					if (sz_init < sz_valid) begin
						dec_act = ACT_FILL;
					end
				end else if (init_fail) begin
					dec_state = ST_INVALID;
					if (cfg.clr_inv) begin
						dec_act = ACT_CLEAR;
					end else if (sz_init < sz_inv) begin
						dec_act = ACT_FILL;
					end
				end
			end
			ST_INVALID: begin
				if (inv_pass) begin
					dec_state = ST_VALID;
					if (sz_inv < sz_valid) begin
						dec_act = ACT_FILL;
					end
				end else if (inv_err) begin
					dec_act = ACT_CLEAR;
				end
			end
			ST_VALID: begin
				if (!inv_pass) begin
					dec_state = ST_INVALID;
					if (cfg.clr_inv) begin
						dec_act = ACT_CLEAR;
					end
				end
			end
		endcase
	end

	always_comb begin
		sq_d = sq_q;
		unique case (sq_q)
			SQ_BOOT:   if (clr_last) sq_d = SQ_IDLE;
			SQ_IDLE:   if (in_valid) sq_d = SQ_WRITE;
			SQ_WRITE:  sq_d = SQ_COUNT;
			SQ_COUNT:  if (count_done) sq_d = SQ_DECIDE;
			SQ_DECIDE: begin
				unique case (dec_act)
					ACT_FILL:  sq_d = SQ_FILL;
					ACT_CLEAR: sq_d = SQ_CLEAR;
					default:   sq_d = SQ_DONE;
				endcase
			end
			SQ_FILL:   if (fill_last) sq_d = SQ_DONE;
			SQ_CLEAR:  if (clr_last) sq_d = SQ_DONE;
			SQ_DONE:   if (out_free) sq_d = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		we       = 1'b0;
		waddr    = top_q;
		wdata    = W_NOTAVAIL;
		raddr    = rd_idx_q[AW-1:0];
		unique case (sq_q)
			SQ_BOOT, SQ_CLEAR: begin
				we    = 1'b1;
				waddr = clr_idx_q;
			end
			SQ_IDLE:  in_ready = 1'b1;
			SQ_WRITE: begin
				we    = 1'b1;
				wdata = status_to_code(status_q);
			end
			SQ_FILL: begin
				we    = 1'b1;
				waddr = fill_idx_q;
				wdata = W_OTHER;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_BOOT;
		end else begin
			sq_q <= sq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sq_q == SQ_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstate_q    <= ST_NODATA;
			top_q       <= '0;
			ok_q        <= '0;
			err_q       <= '0;
			acc_ok_q    <= '0;
			acc_err_q   <= '0;
			status_q    <= '0;
			clr_idx_q   <= '0;
			rd_idx_q    <= '0;
			rd_v_s1     <= 1'b0;
			fill_n_q    <= '0;
			fill_cur_q  <= '0;
			fill_idx_q  <= '0;
			out_state_q <= ST_NODATA;
			out_ok_q    <= '0;
			out_err_q   <= '0;
		end else begin
			case (sq_q)
				SQ_BOOT, SQ_CLEAR: begin
					clr_idx_q <= clr_last ? '0 : clr_idx_q + 1'b1;
				end
				SQ_IDLE: begin
					if (in_valid) begin
						status_q <= profile_status;
					end
				end
				SQ_WRITE: begin
					top_q     <= top_next;
					acc_ok_q  <= '0;
					acc_err_q <= '0;
					rd_idx_q  <= '0;
					rd_v_s1   <= 1'b0;
				end
				SQ_COUNT: begin
					rd_v_s1 <= !count_done;
					if (!count_done) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					if (rd_v_s1) begin
						if (rdata == W_OK) begin
							acc_ok_q <= acc_ok_q + 1'b1;
						end
						if (rdata == W_ERROR) begin
							acc_err_q <= acc_err_q + 1'b1;
						end
					end
				end
				SQ_DECIDE: begin
					mstate_q   <= dec_state;
					fill_cur_q <= sz_cur;
					fill_idx_q <= top_q;
					fill_n_q   <= '0;
					if (dec_act == ACT_CLEAR) begin
						ok_q  <= '0;
						err_q <= '0;
						top_q <= '0;
					end else begin
						ok_q  <= acc_ok_q;
						err_q <= acc_err_q;
					end
				end
				SQ_FILL: begin
					fill_n_q   <= fill_n_q + 1'b1;
					fill_idx_q <= (fill_idx_q != '0) ? fill_idx_q - 1'b1
						: AW'(fill_cur_q - 1'b1);
				end
				SQ_DONE: begin
					if (out_free) begin
						out_state_q <= mstate_q;
						out_ok_q    <= 5'(ok_q);
						out_err_q   <= 5'(err_q);
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign machine_state = out_state_q;
	assign ok_total      = out_ok_q;
	assign error_total   = out_err_q;

	`E2E_CHECK_ALL(a_idle_no_write, (sq_q == SQ_IDLE) |-> !we, "window written while idle")
	`E2E_CHECK(a_count_bound, (TW'(ok_q) + TW'(err_q)) <= TW'(MAX_WINDOW), "counts exceed window")
	`E2E_CHECK(a_fill_in_win, (sq_q == SQ_FILL) |-> (CW'(fill_idx_q) < fill_cur_q), "fill index outside old window")
	`E2E_CHECK(a_accept_write, (in_valid && in_ready) |=> (sq_q == SQ_WRITE && we), "accepted status not written")

endmodule

`default_nettype wire

### rtl/e2e_window_state_machine.sv
// After reset the block sweeps all MAX_WINDOW entries of the status window to
// "not available", while in_ready stays low (register writes still land).
// Each status is then accepted, written into the window RAM and counted over
// the current window of W entries through the single read port; the state
// rules are applied, then, where they call for it, either the W entries of the
// old window are filled with no-new-data or all MAX_WINDOW entries are cleared,
// and the result is handed to the output register once it is free. A new status
// is accepted only when the last one is through. The output register holds a
// result while the next status is already being processed.
`default_nettype none

// ----------------------------------------------------------------------------
// e2e_window_state_machine
// E2E window state machine: top level with APB configuration and handshake.
// ----------------------------------------------------------------------------

module e2e_window_state_machine import e2e_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  profile_status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       machine_state,
	output logic [4:0]       ok_total,
	output logic [4:0]       error_total
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	e2e_cfg_t      cfg;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	win_code_t     wdata, rdata;

	e2e_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	e2e_window_ram #(
		.DEPTH (MAX_WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	e2e_seq #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.profile_status (profile_status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.machine_state  (machine_state),
		.ok_total       (ok_total),
		.error_total    (error_total),
		.we             (we),
		.waddr          (waddr),
		.wdata          (wdata),
		.raddr          (raddr),
		.rdata          (rdata)
	);

endmodule

`default_nettype wire

### bench/e2e_window_state_machine_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2e_window_state_machine_scoreboard
// Watches the APB port and both transfer channels of the E2E window state
// machine, predicts each result from its own model of the status window and
// the state rules, and compares it with what the block delivers.
// ----------------------------------------------------------------------------

module e2e_window_state_machine_scoreboard import e2e_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  profile_status,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  machine_state,
	input  logic [4:0]  ok_total,
	input  logic [4:0]  error_total,
	output int          pending,
	output int          fail_count
);

	typedef struct packed {
		e2e_state_t st;
		logic [4:0] ok;
		logic [4:0] err;
	} sm_result_t;

	e2e_cfg_t   cfg;
	win_code_t  hist [MAX_WINDOW];
	int         hist_top;
	int         ok_cnt;
	int         err_cnt;
	e2e_state_t mstate;
	bit         booted;

	sm_result_t awaited_results [$];
	sm_result_t want;
	int         results_seen;

	function automatic int win_len(input e2e_state_t s);
		int n;
		if (s == ST_INIT)
			n = cfg.win_init;
		else if (s == ST_VALID)
			n = cfg.win_valid;
		else
			n = cfg.win_invalid;
		if (n < 1)
			n = 1;
		if (n > MAX_WINDOW)
			n = MAX_WINDOW;
		return n;
	endfunction

	function automatic void wipe_window();
		ok_cnt = 0;
		err_cnt = 0;
		hist_top = 0;
		foreach (hist[i])
			hist[i] = W_NOTAVAIL;
	endfunction

	// grow-on-transition: walk back from the top marking old entries as no new data
	function automatic void pad_window(input e2e_state_t next);
		int cur;
		int nxt;
		int idx;
		cur = win_len(mstate);
		nxt = win_len(next);
		idx = hist_top;
		if (cur >= nxt)
			return;
		for (int n = 0; n < cur; n++) begin
			if (idx < MAX_WINDOW)
				hist[idx] = W_OTHER;
			idx = (idx != 0 ? idx : cur) - 1;
		end
	endfunction

	function automatic void go_invalid();
		if (cfg.clr_inv)
			wipe_window();
		else
			pad_window(ST_INVALID);
		mstate = ST_INVALID;
	endfunction

	function automatic void record_status(input logic [2:0] s);
		int len;
		win_code_t code;
		len = win_len(mstate);
		case (s)
			PS_OK:        code = W_OK;
			PS_ERROR:     code = W_ERROR;
			PS_NOT_AVAIL: code = W_NOTAVAIL;
			default:      code = W_OTHER;
		endcase
		if (hist_top < MAX_WINDOW)
			hist[hist_top] = code;
		ok_cnt = 0;
		err_cnt = 0;
		for (int i = 0; i < len; i++) begin
			if (hist[i] == W_OK)
				ok_cnt++;
			else if (hist[i] == W_ERROR)
				err_cnt++;
		end
		hist_top = (hist_top + 1 >= len) ? 0 : hist_top + 1;
	endfunction

	function automatic sm_result_t advance_window_sm(input logic [2:0] s);
		sm_result_t r;
		int ws;
		int fill;
		int max_err_ini;
		int min_ok_ini;
		int max_err_inv;
		int min_ok_inv;
		max_err_ini = cfg.max_err_init;
		min_ok_ini = cfg.min_ok_init;
		max_err_inv = cfg.max_err_inv;
		min_ok_inv = cfg.min_ok_inv;
		if (!booted) begin
			wipe_window();
			mstate = ST_NODATA;
			booted = 1'b1;
		end
		record_status(s);
		case (mstate)
			ST_NODATA: begin
				if (hist_top == 0) begin
					go_invalid();
				end else if (s != PS_ERROR && s != PS_NO_NEW_DATA) begin
					wipe_window();
					mstate = ST_INIT;
				end
			end
			ST_INIT: begin
				ws = win_len(ST_INIT);
				fill = (hist_top == 0) ? ws : ((hist_top - 1) % ws) + 1;
				if (err_cnt <= max_err_ini && ok_cnt >= min_ok_ini) begin
					pad_window(ST_VALID);
					mstate = ST_VALID;
				end else if (err_cnt > max_err_ini || fill - ok_cnt > ws - min_ok_ini) begin
					go_invalid();
				end
			end
			ST_INVALID: begin
				if (err_cnt <= max_err_inv && ok_cnt >= min_ok_inv) begin
					pad_window(ST_VALID);
					mstate = ST_VALID;
				end else if (err_cnt > max_err_inv) begin
					wipe_window();
				end
			end
			ST_VALID: begin
				if (!(err_cnt <= max_err_inv && ok_cnt >= min_ok_inv)) begin
					if (cfg.clr_inv)
						wipe_window();
					mstate = ST_INVALID;
				end
			end
			default: ;
		endcase
		r.st = mstate;
		r.ok = ok_cnt[4:0];
		r.err = err_cnt[4:0];
		return r;
	endfunction

	function automatic void report_fail(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("scoreboard: %s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = CFG_RESET;
			booted = 1'b0;
			mstate = ST_NODATA;
			wipe_window();
			awaited_results.delete();
			results_seen = 0;
			pending = 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (cfg_idx_t'(paddr[4:2]))
					REG_WIN_INIT:    cfg.win_init = pwdata[4:0];
					REG_WIN_INVALID: cfg.win_invalid = pwdata[4:0];
					REG_WIN_VALID:   cfg.win_valid = pwdata[4:0];
					REG_MAX_ERR_INI: cfg.max_err_init = pwdata[4:0];
					REG_MIN_OK_INI:  cfg.min_ok_init = pwdata[4:0];
					REG_MAX_ERR_INV: cfg.max_err_inv = pwdata[4:0];
					REG_MIN_OK_INV:  cfg.min_ok_inv = pwdata[4:0];
					REG_CLR_INV:     cfg.clr_inv = pwdata[0];
					default: ;
				endcase
			end
			// output side first: a status cannot produce its result in its own transfer cycle
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_fail($sformatf("result %0d arrived with none outstanding: state %0d ok %0d err %0d",
						results_seen, machine_state, ok_total, error_total));
				end else begin
					want = awaited_results.pop_front();
					if (machine_state !== want.st || ok_total !== want.ok ||
							error_total !== want.err)
						report_fail($sformatf(
							"result %0d: expected state %0d ok %0d err %0d, got state %0d ok %0d err %0d",
							results_seen, want.st, want.ok, want.err,
							machine_state, ok_total, error_total));
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				awaited_results.push_back(advance_window_sm(profile_status));
			pending = awaited_results.size();
		end
	end

endmodule

### bench/e2e_window_state_machine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2e_window_state_machine_tb
// Drives profile check statuses and APB configuration into the E2E window
// state machine through a series of register settings, with random idling
// on both channels and a long output stall; the scoreboard does the checking.
// ----------------------------------------------------------------------------

module e2e_window_state_machine_tb;
	import e2e_pkg::*;

	localparam int MAX_WINDOW  = 16;
	localparam int HOLD_CYCLES = 300;

	localparam logic [2:0] PS_UNKNOWN_6 = 3'd6;
	localparam logic [2:0] PS_UNKNOWN_7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  profile_status = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  machine_state;
	logic [4:0]  ok_total;
	logic [4:0]  error_total;

	int pending;
	int fail_count;

	logic idle_on = 1'b0;
	logic rx_hold_req = 1'b0;
	int   rx_hold_left = 0;
	int   rx_gap_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	e2e_window_state_machine #(.MAX_WINDOW(MAX_WINDOW)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .profile_status(profile_status),
		.out_valid(out_valid), .out_ready(out_ready),
		.machine_state(machine_state), .ok_total(ok_total), .error_total(error_total)
	);

	e2e_window_state_machine_scoreboard #(.MAX_WINDOW(MAX_WINDOW)) status_sb (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_ready(in_ready), .profile_status(profile_status),
		.out_valid(out_valid), .out_ready(out_ready),
		.machine_state(machine_state), .ok_total(ok_total), .error_total(error_total),
		.pending(pending), .fail_count(fail_count)
	);

	// result receiver: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_gap_left != 0) begin
			rx_gap_left <= rx_gap_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			rx_gap_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic cfg_write(input cfg_idx_t idx, input logic [4:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic load_cfg(input e2e_cfg_t c);
		cfg_write(REG_WIN_INIT, c.win_init);
		cfg_write(REG_WIN_INVALID, c.win_invalid);
		cfg_write(REG_WIN_VALID, c.win_valid);
		cfg_write(REG_MAX_ERR_INI, c.max_err_init);
		cfg_write(REG_MIN_OK_INI, c.min_ok_init);
		cfg_write(REG_MAX_ERR_INV, c.max_err_inv);
		cfg_write(REG_MIN_OK_INV, c.min_ok_inv);
		cfg_write(REG_CLR_INV, {4'd0, c.clr_inv});
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic e2e_cfg_t rand_cfg();
		e2e_cfg_t c;
		c.win_init = 5'($urandom_range(1, MAX_WINDOW));
		c.win_invalid = 5'($urandom_range(1, MAX_WINDOW));
		c.win_valid = 5'($urandom_range(1, MAX_WINDOW));
		c.max_err_init = 5'($urandom_range(0, 3));
		c.min_ok_init = 5'($urandom_range(0, c.win_init));
		c.max_err_inv = 5'($urandom_range(0, 3));
		c.min_ok_inv = 5'($urandom_range(0, c.win_valid));
		c.clr_inv = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic send_status(input logic [2:0] s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		profile_status <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// bursts of OK with rare noise, error bursts, and fully random stretches
	task automatic run_random(input int n_items);
		int sent;
		int kind;
		int len;
		logic [2:0] s;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			len = (kind < 5) ? $urandom_range(1, 18) : $urandom_range(1, 5);
			repeat (len) begin
				if (kind < 5) begin
					if ($urandom_range(0, 7) == 0)
						s = 3'($urandom_range(0, 7));
					else
						s = PS_OK;
				end else if (kind < 7) begin
					s = PS_ERROR;
				end else begin
					s = 3'($urandom_range(0, 7));
				end
				send_status(s);
				sent++;
			end
		end
		finish_phase();
	endtask

	initial begin : stimulus
		logic [2:0] opening_seq [] = '{
			PS_NO_NEW_DATA, PS_ERROR, PS_UNKNOWN_7,
			PS_OK, PS_OK,
			PS_REPEATED, PS_WRONG_SEQ, PS_NOT_AVAIL, PS_UNKNOWN_6,
			PS_OK, PS_OK, PS_OK, PS_OK,
			PS_ERROR, PS_OK, PS_OK, PS_OK,
			PS_NO_NEW_DATA, PS_NO_NEW_DATA, PS_UNKNOWN_7,
			PS_ERROR, PS_ERROR, PS_OK, PS_OK
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		idle_on <= 1'b1;

		// power-on settings: no data exit via unknown status, then init and valid
		foreach (opening_seq[i])
			send_status(opening_seq[i]);
		finish_phase();

		// widest windows, strictest thresholds, clear on invalid
		load_cfg('{win_init: 5'd16, win_invalid: 5'd16, win_valid: 5'd16,
			max_err_init: 5'd0, min_ok_init: 5'd16,
			max_err_inv: 5'd0, min_ok_inv: 5'd16, clr_inv: 1'b1});
		run_random(40);

		// single-entry windows
		load_cfg('{win_init: 5'd1, win_invalid: 5'd1, win_valid: 5'd1,
			max_err_init: 5'd0, min_ok_init: 5'd1,
			max_err_inv: 5'd0, min_ok_inv: 5'd1, clr_inv: 1'b0});
		run_random(40);

		// out-of-range sizes get clamped; thresholds that always pass
		load_cfg('{win_init: 5'd0, win_invalid: 5'd31, win_valid: 5'd0,
			max_err_init: 5'd31, min_ok_init: 5'd0,
			max_err_inv: 5'd31, min_ok_inv: 5'd0, clr_inv: 1'b1});
		run_random(30);

		// min ok above any window: valid is never reached
		load_cfg('{win_init: 5'd16, win_invalid: 5'd4, win_valid: 5'd8,
			max_err_init: 5'd0, min_ok_init: 5'd31,
			max_err_inv: 5'd0, min_ok_inv: 5'd31, clr_inv: 1'b0});
		run_random(30);

		// long output stall while statuses keep coming
		load_cfg(CFG_RESET);
		rx_hold_req <= 1'b1;
		@(posedge clk);
		rx_hold_req <= 1'b0;
		run_random(40);

		repeat (4) begin
			load_cfg(rand_cfg());
			run_random(40);
		end

		idle_on <= 1'b0;
		load_cfg(rand_cfg());
		run_random(40);

		repeat (50) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
